// ===== hw/rtl/s256h_pkg.sv =====
// ----------------------------------------------------------------------------
// s256h_pkg
// Widths, round constants, initial hash values and the SHA-256 sigma
// functions that the stream hasher uses.
// ----------------------------------------------------------------------------
package s256h_pkg;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 64;
    localparam int BLK_W   = 512;
    localparam int NWORDS  = 8;
    localparam int IDX_W   = 3;
    localparam int FILL_W  = 6;
    localparam int RND_W   = 6;

    localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h80;
    localparam logic [FILL_W-1:0] LEN_START  = 6'd56;
    localparam logic [FILL_W-1:0] FILL_LAST  = 6'd63;
    localparam logic [RND_W-1:0]  RND_LAST   = 6'd63;
    localparam logic [IDX_W-1:0]  IDX_LAST   = 3'd7;

    // command field codes
    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_H [NWORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t rotr(input word_t v, input int n);
        begin
            rotr = (v >> n) | (v << (WORD_W - n));
        end
    endfunction

    function automatic word_t bsig0(input word_t x);
        begin
            bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
        end
    endfunction

    function automatic word_t bsig1(input word_t x);
        begin
            bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
        end
    endfunction

    function automatic word_t ssig0(input word_t x);
        begin
            ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
        end
    endfunction

    function automatic word_t ssig1(input word_t x);
        begin
            ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
        end
    endfunction

endpackage

// ===== hw/rtl/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-serial SHA-256: gathers message bytes into a 512-bit block, runs one
// compression round per cycle on a shared round unit, emits eight digest words.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | sink      | in_valid/in_stall  | command, data_byte
//  out     | source    | out_valid/out_stall| digest_word, word_index, last_word
//
//  An absorb beat is taken only in idle; the 64th byte of a block starts the
//  rounds and then the fold, with in_stall high until both are done.
//  A finish beat feeds pad and length bytes one per cycle while no block is
//  being compressed (64 - fill bytes, or 128 - fill when fill >= 56), then
//  eight output beats; a full block pauses the feed for its rounds and fold.
//  rst_n clears control and loads the initial hash values; no clearing pass.
//  out_stall holds the current digest word; in_stall stays high meanwhile.
//
module sha256_stream_hasher (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [s256h_pkg::BYTE_W-1:0]  data_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [s256h_pkg::WORD_W-1:0]  digest_word,
    output logic [s256h_pkg::IDX_W-1:0]   word_index,
    output logic                          last_word
);
    import s256h_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    // control
    logic [2:0]        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  bits_reg, bits_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              fin_reg, fin_next;
    logic              first_reg, first_next;
    logic              len_reg, len_next;
    word_t             chain_reg [NWORDS];
    word_t             chain_next [NWORDS];

    // datapath
    logic [BLK_W-1:0]  blk_reg, blk_next;
    word_t             work_reg [NWORDS];
    word_t             work_next [NWORDS];

    logic              feed_en;
    logic [BYTE_W-1:0] feed_byte;
    logic              len_byte;
    word_t             w_t, w_new, t1, t2, ch, maj;

    // message schedule window: word 0 is W[t]; W[t+16] taps words 0, 1, 9, 14 (t, t+1, t+9, t+14)
    assign w_t   = blk_reg[BLK_W-1 -: WORD_W];
    assign w_new = blk_reg[BLK_W-1 -: WORD_W]
                 + ssig0(blk_reg[BLK_W-1-WORD_W -: WORD_W])
                 + blk_reg[BLK_W-1-9*WORD_W -: WORD_W]
                 + ssig1(blk_reg[BLK_W-1-14*WORD_W -: WORD_W]);

    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + bsig1(work_reg[4]) + ch + ROUND_K[rnd_reg] + w_t;
    assign t2  = bsig0(work_reg[0]) + maj;

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_EMIT);
    assign digest_word = chain_reg[0];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == IDX_LAST);

    // length bytes follow once the pad reaches byte 56 of the final block
    assign len_byte = len_reg || (!first_reg && fill_reg == LEN_START);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        first_next = first_reg;
        len_next   = len_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        feed_en    = 1'b0;
        feed_byte  = data_byte;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_ABSORB)
                    begin
                        feed_en   = 1'b1;
                        bits_next = bits_reg + CNT_W'(BYTE_W);
                    end
                    else
                    begin
                        state_next = ST_PAD;
                        fin_next   = 1'b1;
                        first_next = 1'b1;
                        len_next   = 1'b0;
                    end
                end
            end
            ST_PAD:
            begin
                feed_en    = 1'b1;
                first_next = 1'b0;
                if (first_reg)
                begin
                    feed_byte = PAD_BYTE;
                end
                else if (len_byte)
                begin
                    feed_byte = bits_reg[CNT_W-1 -: BYTE_W];
                    bits_next = {bits_reg[CNT_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                    len_next  = 1'b1;
                end
                else
                begin
                    feed_byte = '0;
                end
            end
            ST_COMP:
            begin
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                rnd_next     = rnd_reg + 1'b1;
                if (rnd_reg == RND_LAST)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                for (int i = 0; i < NWORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_reg)
                begin
                    state_next = ST_EMIT;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 1'b1;
                    for (int i = 0; i < NWORDS; i++)
                    begin
                        chain_next[i] = chain_reg[(i + 1) % NWORDS];
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        // back to the initial state for the next message
                        chain_next = INIT_H;
                        bits_next  = '0;
                        fill_next  = '0;
                        fin_next   = 1'b0;
                        len_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // block full: load working vars and start the rounds
        if (feed_en)
        begin
            fill_next = fill_reg + 1'b1;
            if (fill_reg == FILL_LAST)
            begin
                state_next = ST_COMP;
                rnd_next   = '0;
                work_next  = chain_reg;
            end
        end
    end

    always_comb
    begin
        if (feed_en)
        begin
            blk_next = {blk_reg[BLK_W-BYTE_W-1:0], feed_byte};
        end
        else if (state_reg == ST_COMP)
        begin
            blk_next = {blk_reg[BLK_W-WORD_W-1:0], w_new};
        end
        else
        begin
            blk_next = blk_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            first_reg <= 1'b0;
            len_reg   <= 1'b0;
            chain_reg <= INIT_H;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            first_reg <= first_next;
            len_reg   <= len_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        work_reg <= work_next;
    end

`ifndef ASSERT_OFF
    a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while digest pending");

    a_rounds_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP && rnd_reg == RND_LAST) |=> (state_reg == ST_FOLD))
        else $error("round count did not end in fold");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_word)
            |=> (state_reg == ST_IDLE && fill_reg == '0 && bits_reg == '0
                 && chain_reg[0] == INIT_H[0]))
        else $error("state not restored after final digest beat");
`endif

endmodule
